// ===== sv/lsrf_pkg.sv =====
// Package for the limited-slope remap flux block: field widths, step codes,
// jump conditions and the control-word ROM of the sequencer.
// No dependencies; used by limited_slope_remap_flux and lsrf_checker.
package lsrf_pkg;

	localparam int DATA_W = 32;
	localparam int EPS_W  = 16;
	localparam int STEP_W = 3;

	// Sequencer steps
	localparam logic [STEP_W-1:0] ST_WAIT  = 3'd0;
	localparam logic [STEP_W-1:0] ST_DIFF  = 3'd1;
	localparam logic [STEP_W-1:0] ST_SLOPE = 3'd2;
	localparam logic [STEP_W-1:0] ST_MUL_K = 3'd3;
	localparam logic [STEP_W-1:0] ST_SUM   = 3'd4;
	localparam logic [STEP_W-1:0] ST_ROUND = 3'd5;
	localparam logic [STEP_W-1:0] ST_MUL_E = 3'd6;
	localparam logic [STEP_W-1:0] ST_EMIT  = 3'd7;

	// Jump conditions: jump to target when true, else hold the step
	localparam logic [1:0] COND_ALWAYS   = 2'd0;
	localparam logic [1:0] COND_EMIT_IN  = 2'd1;
	localparam logic [1:0] COND_OUT_FREE = 2'd2;

	localparam logic MUL_K_D2 = 1'b0;
	localparam logic MUL_E_B  = 1'b1;

	typedef struct packed {
		logic              ld_diff;
		logic              ld_slope;
		logic              mul_sel;
		logic              ld_prod;
		logic              ld_inner;
		logic              ld_b;
		logic              ld_out;
		logic [1:0]        cond;
		logic [STEP_W-1:0] target;
	} uword_t;

	function automatic uword_t ucode(input logic [STEP_W-1:0] step);
		uword_t w;
		w = '0;
		unique case (step)
			ST_WAIT: begin
				w.cond = COND_EMIT_IN;
				w.target = ST_DIFF;
			end
			ST_DIFF: begin
				w.ld_diff = 1'b1;
				w.target = ST_SLOPE;
			end
			ST_SLOPE: begin
				w.ld_slope = 1'b1;
				w.target = ST_MUL_K;
			end
			ST_MUL_K: begin
				w.mul_sel = MUL_K_D2;
				w.ld_prod = 1'b1;
				w.target = ST_SUM;
			end
			ST_SUM: begin
				w.ld_inner = 1'b1;
				w.target = ST_ROUND;
			end
			ST_ROUND: begin
				w.ld_b = 1'b1;
				w.target = ST_MUL_E;
			end
			ST_MUL_E: begin
				w.mul_sel = MUL_E_B;
				w.ld_prod = 1'b1;
				w.target = ST_EMIT;
			end
			ST_EMIT: begin
				w.ld_out = 1'b1;
				w.cond = COND_OUT_FREE;
				w.target = ST_WAIT;
			end
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

// ===== sv/limited_slope_remap_flux.sv =====
// Limited-slope remap flux: streaming window, MC-limited slope and upwind flux,
// run by a microcoded sequencer over one shared multiplier.
// Depends on lsrf_pkg.
//
// Usage: samples of a column arrive on the s_ channel (s_tdata = sample,
// s_tuser = column start, s_tlast = column end). The block keeps the last two
// samples; from the third sample of a column on, each item yields one flux on
// the m_ channel (m_tdata = flux, m_tlast = set on the column's last flux).
// Columns shorter than three samples give nothing. shift_fraction (Q1.15) is
// for the user to write through cfg_we/cfg_wdata only while the block is idle;
// the block does not enforce this. It resets to 0. An item that yields no flux
// leaves the sequencer in its wait step. An item that yields a flux walks the
// eight-step microprogram (diff, slope, two passes through the one multiplier,
// bracket sum and two rounds), and the input stays closed until the sequencer
// is back in its wait step. The result sits in an output register: the block
// takes and works on the next item while m_tready is low, and only the final
// step waits for the register to free up. Reset empties the window, clears the
// output valid flag and returns the sequencer to its wait step.
module limited_slope_remap_flux #(
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lsrf_pkg::EPS_W-1:0]     cfg_wdata,  // shift_fraction
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [lsrf_pkg::DATA_W-1:0]    s_tdata,    // [31:0] sample
	input  logic                           s_tuser,    // [0] column_start
	input  logic                           s_tlast,    // column_end
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [lsrf_pkg::DATA_W-1:0]    m_tdata,    // [31:0] flux_value
	output logic                           m_tlast     // is_last
);
	import lsrf_pkg::*;

	localparam int EW = (SAMPLE_WIDTH > DATA_W) ? DATA_W : SAMPLE_WIDTH;
	localparam int MA = EW + 3;   // multiplier wide operand: slope or bracket
	localparam int MB = EPS_W + 1;
	localparam int PW = MA + MB;  // product and bracket sum
	localparam int FW = PW - 15;  // flux before saturation
	localparam logic signed [FW-1:0] SAT_HI = {{(FW-EW+1){1'b0}}, {(EW-1){1'b1}}};
	localparam logic signed [FW-1:0] SAT_LO = {{(FW-EW+1){1'b1}}, {(EW-1){1'b0}}};

	logic [STEP_W-1:0]      step_q;
	uword_t                 uw;
	logic                   take;

	logic signed [EPS_W-1:0] eps_q;
	logic signed [EW-1:0]   older_q, middle_q, left_q;
	logic [1:0]             fill_q;
	logic                   last_q;

	logic                   in_acc;
	logic signed [EW-1:0]   in_s;
	logic [1:0]             fill_eff;
	logic                   emit;

	logic signed [EW:0]     dl_q, dr_q, dc_q;
	logic signed [MA-1:0]   d2_q, b_q;
	logic signed [PW-1:0]   prod_q, inner_q;

	logic                   out_valid_q;
	logic [DATA_W-1:0]      flux_q;
	logic                   out_last_q;

	// next-state logic
	logic                   eps_pos;
	logic signed [MB-1:0]   eps_ext, k_fac;
	logic [EW:0]            mag_l, mag_r, mag_c, lim;
	logic [MA-1:0]          lim4, half2, d2_mag;
	logic signed [MA-1:0]   d2_mag_s, d2_n;
	logic                   same_sign;
	logic signed [MA-1:0]   mul_a;
	logic signed [MB-1:0]   mul_b;
	logic signed [PW-1:0]   mul_p, u_sh, inner_n;
	logic [PW-1:0]          rnd_b, rnd_f;
	logic signed [FW-1:0]   f_full;
	logic signed [EW-1:0]   f_sat;

	assign uw = ucode(step_q);
	assign s_tready = (step_q == ST_WAIT);
	assign in_acc = s_tvalid && s_tready;
	assign in_s = s_tdata[EW-1:0];
	assign fill_eff = s_tuser ? 2'd0 : fill_q;
	assign emit = fill_eff[1];

	always_comb begin
		unique case (uw.cond)
			COND_ALWAYS:   take = 1'b1;
			COND_EMIT_IN:  take = in_acc && emit;
			COND_OUT_FREE: take = !out_valid_q || m_tready;
			default:       take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_WAIT;
		end else if (take) begin
			step_q <= uw.target;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= '0;
		end else if (cfg_we) begin
			eps_q <= cfg_wdata;
		end
	end

	// Window: after an accept older_q holds the middle sample u and middle_q
	// the new sample c; left_q keeps a for the difference step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q <= '0;
			middle_q <= '0;
			fill_q <= '0;
		end else if (in_acc) begin
			older_q <= middle_q;
			middle_q <= in_s;
			if (s_tlast) begin
				fill_q <= '0;
			end else if (!fill_eff[1]) begin
				fill_q <= fill_eff + 2'd1;
			end else begin
				fill_q <= fill_eff;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			left_q <= older_q;
			last_q <= s_tlast;
		end
	end

	// Slope
	always_comb begin
		mag_l = dl_q[EW] ? (EW+1)'(-dl_q) : dl_q;
		mag_r = dr_q[EW] ? (EW+1)'(-dr_q) : dr_q;
		mag_c = dc_q[EW] ? (EW+1)'(-dc_q) : dc_q;
		lim = (mag_l < mag_r) ? mag_l : mag_r;
		lim4 = {lim, 2'b00};
		half2 = {2'b00, mag_c};
		same_sign = (!dl_q[EW] && dl_q != '0 && !dr_q[EW] && dr_q != '0)
			|| (dl_q[EW] && dr_q[EW]);
		d2_mag = !same_sign ? '0 : ((half2 < lim4) ? half2 : lim4);
		d2_mag_s = d2_mag;
		d2_n = dc_q[EW] ? -d2_mag_s : d2_mag_s;
	end

	// Shared multiplier: (1 -/+ eps) * slope, then eps * bracket
	always_comb begin
		eps_pos = !eps_q[EPS_W-1] && (eps_q != '0);
		eps_ext = MB'(eps_q);
		k_fac = eps_pos ? (MB'(32768) - eps_ext) : (MB'(32768) + eps_ext);
		mul_a = (uw.mul_sel == MUL_E_B) ? b_q : d2_q;
		mul_b = (uw.mul_sel == MUL_E_B) ? eps_ext : k_fac;
		mul_p = mul_a * mul_b;
		u_sh = PW'(older_q) <<< 17;
		inner_n = eps_pos ? (u_sh + prod_q) : (u_sh - prod_q);
	end

	// Round to nearest, ties away from zero: add half, less one when negative.
	always_comb begin
		rnd_b = inner_q + PW'(65536) - PW'(inner_q[PW-1]);
		rnd_f = prod_q + PW'(16384) - PW'(prod_q[PW-1]);
		f_full = rnd_f[PW-1:15];
		if (f_full > SAT_HI) begin
			f_sat = SAT_HI[EW-1:0];
		end else if (f_full < SAT_LO) begin
			f_sat = SAT_LO[EW-1:0];
		end else begin
			f_sat = f_full[EW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (take && uw.ld_diff) begin
			dl_q <= (EW+1)'(older_q) - (EW+1)'(left_q);
			dr_q <= (EW+1)'(middle_q) - (EW+1)'(older_q);
			dc_q <= (EW+1)'(middle_q) - (EW+1)'(left_q);
		end
		if (take && uw.ld_slope) begin
			d2_q <= d2_n;
		end
		if (take && uw.ld_prod) begin
			prod_q <= mul_p;
		end
		if (take && uw.ld_inner) begin
			inner_q <= inner_n;
		end
		if (take && uw.ld_b) begin
			b_q <= rnd_b[PW-1:17];
		end
		if (take && uw.ld_out) begin
			flux_q <= DATA_W'(f_sat);
			out_last_q <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && uw.ld_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = flux_q;
	assign m_tlast = out_last_q;

endmodule

// ===== sv/lsrf_checker.sv =====
// Port-level checks for limited_slope_remap_flux, bound to the top level.
// Depends on lsrf_pkg.
module lsrf_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [lsrf_pkg::DATA_W-1:0] m_tdata,
	input logic                        m_tlast
);
	import lsrf_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// a new result comes only after the full program ran with input closed
	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready, 1) && !$past(s_tready, 7))
		else $error("result without a full sequencer pass");

	// sequencer is back in its wait step when a new result shows up
	a_out_then_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("sequencer did not return to wait after emit");

	// after a flux-producing accept the input stays closed for the whole program
	a_seq_gap: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready ##1 !s_tready |-> !s_tready [*7])
		else $error("input reopened without emit step");

endmodule

bind limited_slope_remap_flux lsrf_checker u_lsrf_checker (.*);

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Testbench for limited_slope_remap_flux: column streams under random handshake
// gaps, each flux checked against an in-bench window and flux predictor.
// Depends on lsrf_pkg and limited_slope_remap_flux.
module tb;
	import lsrf_pkg::*;

	localparam int     HOLD_CYCLES   = 300;
	localparam int     SETTLE_CYCLES = 20;
	localparam int     CYCLE_LIMIT   = 400000;
	localparam longint SAT_HI        = 64'sd2147483647;
	localparam longint SAT_LO        = -64'sd2147483648;

	typedef struct {
		logic signed [DATA_W-1:0] flux;
		logic                     last;
	} flux_item_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [EPS_W-1:0]  cfg_wdata;
	logic              s_tvalid;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata;   // [31:0] sample
	logic              s_tuser;   // [0] column_start
	logic              s_tlast;   // column_end
	logic              m_tvalid;
	logic              m_tready;
	logic [DATA_W-1:0] m_tdata;   // [31:0] flux_value
	logic              m_tlast;   // is_last

	// predictor state
	flux_item_t               pending_flux[$];
	logic signed [DATA_W-1:0] win_old = '0;
	logic signed [DATA_W-1:0] win_mid = '0;
	int unsigned              win_fill = 0;
	logic signed [EPS_W-1:0]  eps_q = '0;

	int          src_idle_pct = 0;
	int          sink_stall_pct = 0;
	bit          hold_request = 1'b0;
	int          err_count = 0;
	int unsigned cycle_count = 0;

	limited_slope_remap_flux i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic longint mag_of(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	// divide by 2^s, nearest, ties away from zero
	function automatic longint round_away(input longint v, input int unsigned s);
		longint m, r;
		m = mag_of(v);
		r = (m + (longint'(1) << (s - 1))) >> s;
		return (v < 0) ? -r : r;
	endfunction

	// a = older, u = middle, c = newest sample; e = shift in Q1.15
	function automatic logic signed [DATA_W-1:0] remap_flux(input longint a, input longint u,
			input longint c, input longint e);
		longint dc, dl, dr, lim, d2, inner, b, f;
		dc = c - a;
		dl = u - a;
		dr = c - u;
		d2 = 0;
		// slope only where the middle sample is not an extremum; d2 = 2*|m|
		if ((dl > 0 && dr > 0) || (dl < 0 && dr < 0)) begin
			lim = (mag_of(dl) < mag_of(dr)) ? mag_of(dl) : mag_of(dr);
			d2 = (mag_of(dc) < 4 * lim) ? mag_of(dc) : 4 * lim;
		end
		if (dc < 0)
			d2 = -d2;
		if (e > 0)
			inner = u * 131072 + (32768 - e) * d2;
		else
			inner = u * 131072 - (32768 + e) * d2;
		b = round_away(inner, 17);
		f = round_away(b * e, 15);
		if (f > SAT_HI)
			f = SAT_HI;
		if (f < SAT_LO)
			f = SAT_LO;
		return f[DATA_W-1:0];
	endfunction

	task automatic push_sample(input logic [DATA_W-1:0] smp, input logic col_start,
			input logic col_end);
		flux_item_t res;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= smp;
		s_tuser <= col_start;
		s_tlast <= col_end;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		// item taken at this edge: advance the window
		if (col_start)
			win_fill = 0;
		if (win_fill >= 2) begin
			res.flux = remap_flux(win_old, win_mid, $signed(smp), eps_q);
			res.last = col_end;
			pending_flux.push_back(res);
		end
		win_old = win_mid;
		win_mid = smp;
		if (win_fill < 2)
			win_fill++;
		if (col_end)
			win_fill = 0;
	endtask

	// short columns leave no result, so wait for the queue to drain, then let the block settle
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_flux.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_shift(input logic signed [EPS_W-1:0] eps);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= eps;
		@(posedge clk);
		cfg_we <= 1'b0;
		eps_q = eps;
	endtask

	// random walk with flats, jumps and rail values
	task automatic send_column(input int len, input bit mark_start, input bit mark_end);
		logic [DATA_W-1:0] smp;
		smp = $urandom;
		for (int k = 0; k < len; k++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: smp = smp + $urandom_range(0, 4095) - 2048;
				5: smp = smp + $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
				6, 7: smp = smp;
				8: smp = $urandom;
				default: smp = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			endcase
			push_sample(smp, mark_start && k == 0, mark_end && k == len - 1);
		end
	endtask

	task automatic test_directed();
		// shift still at its reset value of zero
		push_sample(32'h0001_0000, 1'b1, 1'b0);
		push_sample(32'h0003_0000, 1'b0, 1'b0);
		push_sample(32'h0002_0000, 1'b0, 1'b1);
		// rails, monotone run, flat right side
		set_shift(16'sh7FFF);
		push_sample(32'h8000_0000, 1'b1, 1'b0);
		push_sample(32'h0000_0000, 1'b0, 1'b0);
		push_sample(32'h7FFF_FFFF, 1'b0, 1'b0);
		push_sample(32'h7FFF_FFFF, 1'b0, 1'b0);
		push_sample(32'h0000_0000, 1'b0, 1'b1);
		// short columns, then a column with no start mark
		push_sample(32'h1234_5678, 1'b1, 1'b1);
		push_sample(32'h0000_1000, 1'b1, 1'b0);
		push_sample(32'h0000_2000, 1'b0, 1'b1);
		push_sample(32'h0001_0000, 1'b0, 1'b0);
		push_sample(32'h0003_0000, 1'b0, 1'b0);
		push_sample(32'h0002_0000, 1'b0, 1'b1);
		// shift of -1.0: flux is -u, saturates for the most negative u
		set_shift(16'sh8000);
		push_sample(32'h0000_1000, 1'b1, 1'b0);
		push_sample(32'h8000_0000, 1'b0, 1'b0);
		push_sample(32'h0000_1000, 1'b0, 1'b1);
		set_shift(-16'sd32767);
		push_sample(32'h0001_0000, 1'b1, 1'b0);
		push_sample(32'h0002_0000, 1'b0, 1'b0);
		push_sample(32'h0005_0000, 1'b0, 1'b0);
		push_sample(32'h0006_0000, 1'b0, 1'b1);
	endtask

	task automatic test_random_columns(input int src_pct, input int sink_pct,
			input int phase_items);
		int sent, len;
		logic signed [EPS_W-1:0] eps;
		src_idle_pct = src_pct;
		sink_stall_pct = sink_pct;
		for (int seg = 0; seg < 3; seg++) begin
			case ($urandom_range(0, 5))
				0: eps = 16'sh7FFF;
				1: eps = 16'sh8000;
				2: eps = -16'sd32767;
				3: eps = '0;
				default: eps = EPS_W'($urandom);
			endcase
			set_shift(eps);
			sent = 0;
			while (sent < phase_items / 3) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 16);
				send_column(len, $urandom_range(0, 19) != 0, $urandom_range(0, 19) != 0);
				sent += len;
			end
		end
	endtask

	// long receiver hold while the sender keeps offering: input must back up
	task automatic test_output_hold();
		src_idle_pct = 0;
		sink_stall_pct = 0;
		set_shift(EPS_W'($urandom));
		hold_request = 1'b1;
		send_column(30, 1'b1, 1'b1);
		send_column(30, 1'b1, 1'b1);
		wait_idle();
	endtask

	initial begin : flux_sink
		flux_item_t want;
		int hold_left;
		hold_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (pending_flux.size() == 0) begin
					$error("unexpected item: flux_value %h is_last %b", m_tdata, m_tlast);
					err_count++;
				end else begin
					want = pending_flux.pop_front();
					if (m_tdata !== want.flux) begin
						$error("flux_value: expected %h, got %h", want.flux, m_tdata);
						err_count++;
					end
					if (m_tlast !== want.last) begin
						$error("is_last: expected %b, got %b", want.last, m_tlast);
						err_count++;
					end
				end
			end
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		s_tlast <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_columns(22, 69, 280);
		test_random_columns(69, 22, 280);
		test_random_columns(0, 0, 280);
		test_output_hold();
		wait_idle();
		if (err_count == 0 && pending_flux.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
